### rtl/dfr_pkg.sv
// shared types and constants for the xor checked datagram deframer
package dfr_pkg;

	localparam int DG_BYTES_DEF  = 16;
	localparam int BUF_BYTES_DEF = 64;

	localparam int AGE_W   = 32;
	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 6;

	localparam logic [BYTE_W-1:0] HEADER_FIRST  = 8'hAA;
	localparam logic [BYTE_W-1:0] HEADER_SECOND = 8'h1A;

	localparam logic [AGE_W-1:0] AGE_SATURATED = '1;
	localparam logic [AGE_W-1:0] MAX_AGE_RESET = 32'd5000;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	typedef struct packed {
		logic found;
		logic fresh;
	} scan_res_t;

endpackage

### rtl/dfr_item_if.sv
// input word channel: received byte or millisecond tick
interface dfr_item_if;
	logic              valid;
	logic              ready;
	dfr_pkg::kind_t    kind;
	logic [7:0]        rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

### rtl/dfr_result_if.sv
// result word channel: frame bytes and freshness
interface dfr_result_if;
	logic       valid;
	logic       ready;
	logic       carries_frame;
	logic [7:0] frame_byte;
	logic [5:0] byte_index;
	logic       last;
	logic       data_fresh;

	modport source (output valid, output carries_frame, output frame_byte,
		output byte_index, output last, output data_fresh, input ready);
	modport sink   (input valid, input carries_frame, input frame_byte,
		input byte_index, input last, input data_fresh, output ready);
endinterface

### rtl/dfr_cfg_if.sv
// configuration write channel for max_valid_age
interface dfr_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/dfr_scan.sv
// byte window, clear count, age counter and frame detection
module dfr_scan #(
	parameter int DATAGRAM_BYTES = dfr_pkg::DG_BYTES_DEF,
	parameter int BUFFER_BYTES   = dfr_pkg::BUF_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  dfr_pkg::kind_t             kind,
	input  logic [7:0]                 rx_byte,
	input  logic [dfr_pkg::AGE_W-1:0]  max_age,
	output dfr_pkg::scan_res_t         res,
	output logic [7:0]                 window_next [DATAGRAM_BYTES]
);
	import dfr_pkg::*;

	localparam int CW = $clog2(BUFFER_BYTES);

	logic [BYTE_W-1:0] win_q [DATAGRAM_BYTES];
	logic [CW-1:0]     cnt_q;
	logic [AGE_W-1:0]  age_q;

	logic              clr;
	logic [CW-1:0]     cnt_base;
	logic [CW-1:0]     cnt_inc;
	logic [BYTE_W-1:0] sum;
	logic [AGE_W-1:0]  age_inc;
	logic [AGE_W-1:0]  age_after;
	logic              found;

	always_comb begin
		clr = cnt_q >= CW'(BUFFER_BYTES - 1);
		for (int i = 0; i < DATAGRAM_BYTES - 1; i++) begin
			window_next[i] = clr ? '0 : win_q[i+1];
		end
		window_next[DATAGRAM_BYTES-1] = rx_byte;
		cnt_base = clr ? '0 : cnt_q;
		cnt_inc  = cnt_base + CW'(1);
		sum = '0;
		for (int i = 1; i < DATAGRAM_BYTES; i++) begin
			sum = sum ^ window_next[i];
		end
		found = (kind == KIND_BYTE) && (8'(cnt_inc) >= 8'(DATAGRAM_BYTES))
			&& (window_next[0] == HEADER_FIRST) && (window_next[1] == HEADER_SECOND)
			&& (sum == '0);
		age_inc   = (age_q == AGE_SATURATED) ? age_q : age_q + AGE_W'(1);
		age_after = (kind == KIND_TICK) ? age_inc : age_q;
		res.found = found;
		res.fresh = found | (age_after <= max_age);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DATAGRAM_BYTES; i++) begin
				win_q[i] <= '0;
			end
			cnt_q <= '0;
			age_q <= AGE_SATURATED;
		end else if (step) begin
			unique case (kind)
				KIND_TICK: begin
					age_q <= age_inc;
				end
				KIND_BYTE: begin
					if (found) begin
						for (int i = 0; i < DATAGRAM_BYTES; i++) begin
							win_q[i] <= '0;
						end
						cnt_q <= '0;
						age_q <= '0;
					end else begin
						win_q <= window_next;
						cnt_q <= cnt_inc;
					end
				end
				default: begin
					age_q <= age_q;
				end
			endcase
		end
	end

endmodule

### rtl/xor_checked_datagram_deframer_core.sv
// top level of the xor checked datagram deframer
// an accepted word is held in the input register, then scanned into the result register
// throughput: one input word per cycle while results are taken; a found frame drains DATAGRAM_BYTES
// result words, one per cycle while result.ready is high, and input waits until the last is taken
// reset: window and count cleared, age saturated (not fresh), max_valid_age 5000
module xor_checked_datagram_deframer_core #(
	parameter int DATAGRAM_BYTES = dfr_pkg::DG_BYTES_DEF,
	parameter int BUFFER_BYTES   = dfr_pkg::BUF_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	dfr_item_if.sink      item,
	dfr_result_if.source  result,
	dfr_cfg_if.sink       cfg
);
	import dfr_pkg::*;

	localparam int IW = (DATAGRAM_BYTES > 1) ? $clog2(DATAGRAM_BYTES) : 1;

	logic [AGE_W-1:0]  max_age_q;

	logic              valid_s1;
	kind_t             kind_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic              res_valid_q;
	logic              carries_q;
	logic              fresh_q;
	logic [IW-1:0]     idx_q;
	logic [BYTE_W-1:0] frm_q [DATAGRAM_BYTES];

	scan_res_t         scan;
	logic [BYTE_W-1:0] window_next [DATAGRAM_BYTES];
	logic              res_last;
	logic              out_free;
	logic              advance;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= MAX_AGE_RESET;
		end else if (cfg.valid) begin
			max_age_q <= cfg.data;
		end
	end

	assign res_last   = !carries_q || (idx_q == IW'(DATAGRAM_BYTES - 1));
	assign out_free   = !res_valid_q || (result.ready && res_last);
	assign advance    = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1 <= item.kind;
			byte_s1 <= item.rx_byte;
		end
	end

	dfr_scan #(
		.DATAGRAM_BYTES (DATAGRAM_BYTES),
		.BUFFER_BYTES   (BUFFER_BYTES)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.kind        (kind_s1),
		.rx_byte     (byte_s1),
		.max_age     (max_age_q),
		.res         (scan),
		.window_next (window_next)
	);

	// result register and frame drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			carries_q   <= 1'b0;
			idx_q       <= '0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
			carries_q   <= scan.found;
			idx_q       <= '0;
		end else if (res_valid_q && result.ready) begin
			if (res_last) begin
				res_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fresh_q <= scan.fresh;
			frm_q   <= window_next;
		end else if (res_valid_q && result.ready && !res_last) begin
			for (int i = 0; i < DATAGRAM_BYTES - 1; i++) begin
				frm_q[i] <= frm_q[i+1];
			end
			frm_q[DATAGRAM_BYTES-1] <= '0;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.carries_frame = carries_q;
	assign result.frame_byte    = carries_q ? frm_q[0] : '0;
	assign result.byte_index    = carries_q ? INDEX_W'(idx_q) : '0;
	assign result.last          = res_last;
	assign result.data_fresh    = fresh_q;

endmodule
